// ===== hw/rtl/lsp_pkg.sv =====
// ----------------------------------------------------------------------------
// lsp_pkg
// Shared types, widths, constants and the sine table function of the Lab
// split-tone pixel pipeline.
// ----------------------------------------------------------------------------
package lsp_pkg;

   localparam int unsigned LSP_SINE_DEPTH = 1024;

   localparam int unsigned LIGHT_W  = 15;
   localparam int unsigned CH_W     = 16;
   localparam int unsigned EXTRA_W  = 32;
   localparam int unsigned HUE_W    = 16;
   localparam int unsigned CHROMA_W = 15;
   localparam int unsigned LUM_W    = 17;   // Q0.16 fraction up to 1.0
   localparam int unsigned NUM_W    = 34;   // divider numerator
   localparam int unsigned RA_W     = 31;   // tone weight, capped at 2^31-1
   localparam int unsigned SHIFT_W  = LUM_W + RA_W;
   localparam int unsigned TRIG_W   = 17;   // Q1.15 sine, -1.0 .. 1.0
   localparam int unsigned CSR_W    = 16;
   localparam int unsigned CSR_IDX_W = 3;

   localparam logic [LIGHT_W-1:0] L_MAX = LIGHT_W'(25600);
   // floor(x*64/25) == floor(x*RECIP25 / 2^20) for x up to 25600
   localparam int unsigned RECIP_W     = 22;
   localparam logic [RECIP_W-1:0] RECIP25 = RECIP_W'(2684355);
   localparam int unsigned RECIP_SHIFT = 20;
   localparam int unsigned FRAC_ONE    = 65536;
   localparam logic [RA_W-1:0] RA_MAX  = {RA_W{1'b1}};

   localparam longint unsigned Q28_ONE    = 64'd268435456;
   localparam longint unsigned TWO_PI_Q28 = 64'd1686629713;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DARK_HUE      = 3'd0,
      CSR_DARK_CHROMA   = 3'd1,
      CSR_BRIGHT_HUE    = 3'd2,
      CSR_BRIGHT_CHROMA = 3'd3,
      CSR_BALANCE       = 3'd4,
      CSR_COMPRESS      = 3'd5,
      CSR_HAS_CHROMA    = 3'd6
   } lsp_csr_type;

   typedef enum logic [1:0] {
      REGION_MID       = 2'd0,
      REGION_SHADOW    = 2'd1,
      REGION_HIGHLIGHT = 2'd2
   } lsp_region_type;

   typedef struct packed {
      logic [HUE_W-1:0]    dark_hue;
      logic [CHROMA_W-1:0] dark_chroma;
      logic [HUE_W-1:0]    bright_hue;
      logic [CHROMA_W-1:0] bright_chroma;
      logic [HUE_W-1:0]    balance;
      logic [CHROMA_W-1:0] compress;
      logic                has_chroma;
   } lsp_cfg_type;

   typedef struct packed {
      logic [LIGHT_W-1:0] lightness;
      logic [CH_W-1:0]    chan_a;
      logic [CH_W-1:0]    chan_b;
      logic [EXTRA_W-1:0] extra_word;
      logic               frame_end;
   } lsp_pixel_type;

   typedef struct packed {
      lsp_pixel_type      pix;
      lsp_region_type     region;
      logic [NUM_W-1:0]   rem;
      logic [LUM_W-1:0]   den;
      logic [RA_W-1:0]    quot;
      logic               sat;
   } lsp_div_type;

   typedef struct packed {
      logic [LIGHT_W-1:0] out_lightness;
      logic [CH_W-1:0]    out_a;
      logic [CH_W-1:0]    out_b;
      logic [EXTRA_W-1:0] out_extra;
      lsp_region_type     tone_region;
      logic               out_frame_end;
   } lsp_result_type;

   // Sine of turn[15:0]/65536 of a turn in Q1.15: fold into one quadrant,
   // Taylor series to x^11 in Q28, round to Q15.
   function automatic logic signed [TRIG_W-1:0] lsp_turn_sine(input logic [31:0] turn);
      logic [1:0]               quad;
      longint unsigned          f;
      longint unsigned          r;
      longint unsigned          r2;
      longint unsigned          t;
      longint unsigned          s;
      logic signed [TRIG_W-1:0] m;
      quad = turn[15:14];
      f = longint'(turn[13:0]);
      if (quad[0]) begin
         f = 64'd16384 - f;
      end
      r  = (f * TWO_PI_Q28) >> 16;
      r2 = (r * r) >> 28;
      t  = Q28_ONE - r2 / 110;
      t  = Q28_ONE - ((r2 * t) >> 28) / 72;
      t  = Q28_ONE - ((r2 * t) >> 28) / 42;
      t  = Q28_ONE - ((r2 * t) >> 28) / 20;
      t  = Q28_ONE - ((r2 * t) >> 28) / 6;
      s  = (r * t) >> 28;
      s  = (s + 64'd4096) >> 13;
      if (s > 64'd32768) begin
         s = 64'd32768;
      end
      m = TRIG_W'(s);
      return quad[1] ? -m : m;
   endfunction

endpackage

// ===== hw/rtl/lsp_req_if.sv =====
// ----------------------------------------------------------------------------
// lsp_req_if
// Pixel request channel: valid/ready handshake with one Lab pixel per beat.
// ----------------------------------------------------------------------------
interface lsp_req_if;
   logic        valid;
   logic        ready;
   logic [14:0] lightness;
   logic [15:0] chan_a;
   logic [15:0] chan_b;
   logic [31:0] extra_word;
   logic        frame_end;

   modport source (output valid, output lightness, output chan_a, output chan_b,
                   output extra_word, output frame_end, input ready);
   modport sink   (input valid, input lightness, input chan_a, input chan_b,
                   input extra_word, input frame_end, output ready);
endinterface

// ===== hw/rtl/lsp_rsp_if.sv =====
// ----------------------------------------------------------------------------
// lsp_rsp_if
// Toned pixel response channel: valid/ready handshake, one pixel per beat.
// ----------------------------------------------------------------------------
interface lsp_rsp_if;
   logic        valid;
   logic        ready;
   logic [14:0] out_lightness;
   logic [15:0] out_a;
   logic [15:0] out_b;
   logic [31:0] out_extra;
   logic [1:0]  tone_region;
   logic        out_frame_end;

   modport source (output valid, output out_lightness, output out_a, output out_b,
                   output out_extra, output tone_region, output out_frame_end,
                   input ready);
   modport sink   (input valid, input out_lightness, input out_a, input out_b,
                   input out_extra, input tone_region, input out_frame_end,
                   output ready);
endinterface

// ===== hw/rtl/lab_split_tone_pixel.sv =====
// ----------------------------------------------------------------------------
// lab_split_tone_pixel
// Split toning of Lab pixels: shadows and highlights get their own tint on
// the a/b channels, weighted by distance past the split thresholds.
// ----------------------------------------------------------------------------
//
//   port      direction  beat contents
//   req_if    in         lightness, chan_a, chan_b, extra_word, frame_end
//   rsp_if    out        out_lightness, out_a, out_b, out_extra, tone_region,
//                        out_frame_end
//   csr_*     in         write enable, register index, 16-bit write data
//
// One beat enters per clock while the response is not stalled; a beat runs
// through 4 front stages, 31 divider stages (one quotient bit of the tone
// weight each) and 7 tint stages ending in the output register.
// Reset is synchronous and clears all valid bits and loads the register
// defaults; no clearing pass is needed.
// A stalled response freezes the whole pipeline in place, so req_if.ready
// drops in the same cycle and nothing is lost or repeated.
// ----------------------------------------------------------------------------
module lab_split_tone_pixel import lsp_pkg::*; #(
   parameter int unsigned SINE_TABLE_DEPTH = LSP_SINE_DEPTH
) (
   input  logic                 clock,
   input  logic                 reset,
   lsp_req_if.sink              req_if,
   lsp_rsp_if.source            rsp_if,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata
);

   lsp_cfg_type    cfg_ff;
   logic           advance;
   lsp_pixel_type  in_pix;
   logic           div_valid [RA_W+1];
   lsp_div_type    div_item  [RA_W+1];
   logic           out_valid;
   lsp_result_type out_result;

   // Configuration registers; writes to unused indexes are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dark_hue      <= '0;
         cfg_ff.dark_chroma   <= CHROMA_W'(7680);
         cfg_ff.bright_hue    <= HUE_W'(13107);
         cfg_ff.bright_chroma <= CHROMA_W'(7680);
         cfg_ff.balance       <= HUE_W'(32768);
         cfg_ff.compress      <= CHROMA_W'(8448);
         cfg_ff.has_chroma    <= 1'b1;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_DARK_HUE:      cfg_ff.dark_hue      <= csr_wdata;
            CSR_DARK_CHROMA:   cfg_ff.dark_chroma   <= csr_wdata[CHROMA_W-1:0];
            CSR_BRIGHT_HUE:    cfg_ff.bright_hue    <= csr_wdata;
            CSR_BRIGHT_CHROMA: cfg_ff.bright_chroma <= csr_wdata[CHROMA_W-1:0];
            CSR_BALANCE:       cfg_ff.balance       <= csr_wdata;
            CSR_COMPRESS:      cfg_ff.compress      <= csr_wdata[CHROMA_W-1:0];
            CSR_HAS_CHROMA:    cfg_ff.has_chroma    <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   // Advance every stage together unless a finished beat is held back.
   assign advance      = !out_valid || rsp_if.ready;
   assign req_if.ready = advance;

   always_comb begin
      in_pix.lightness  = req_if.lightness;
      in_pix.chan_a     = req_if.chan_a;
      in_pix.chan_b     = req_if.chan_b;
      in_pix.extra_word = req_if.extra_word;
      in_pix.frame_end  = req_if.frame_end;
   end

   lsp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .cfg       (cfg_ff),
      .in_valid  (req_if.valid),
      .in_pix    (in_pix),
      .out_valid (div_valid[0]),
      .out_item  (div_item[0])
   );

   // Divider chain, most significant quotient bit first.
   for (genvar k = 0; k < RA_W; k++) begin : g_div
      lsp_div_stage #(
         .BIT (RA_W - 1 - k)
      ) u_div_stage (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (div_valid[k]),
         .in_item   (div_item[k]),
         .out_valid (div_valid[k+1]),
         .out_item  (div_item[k+1])
      );
   end

   lsp_tint #(
      .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
   ) u_tint (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .cfg        (cfg_ff),
      .in_valid   (div_valid[RA_W]),
      .in_item    (div_item[RA_W]),
      .out_valid  (out_valid),
      .out_result (out_result)
   );

   assign rsp_if.valid         = out_valid;
   assign rsp_if.out_lightness = out_result.out_lightness;
   assign rsp_if.out_a         = out_result.out_a;
   assign rsp_if.out_b         = out_result.out_b;
   assign rsp_if.out_extra     = out_result.out_extra;
   assign rsp_if.tone_region   = out_result.tone_region;
   assign rsp_if.out_frame_end = out_result.out_frame_end;

endmodule

// ===== hw/rtl/lsp_front.sv =====
// ----------------------------------------------------------------------------
// lsp_front
// Four pipeline stages: lightness scaling, split thresholds, region decision
// with the weight numerator, and divider setup with saturation detect.
// ----------------------------------------------------------------------------
module lsp_front import lsp_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          advance,
   input  lsp_cfg_type   cfg,
   input  logic          in_valid,
   input  lsp_pixel_type in_pix,
   output logic          out_valid,
   output lsp_div_type   out_item
);

   localparam int unsigned PROD1_W = LIGHT_W + RECIP_W;
   localparam int unsigned PROD2_W = 2 * (LUM_W + 1);

   // stage 1
   logic [LIGHT_W-1:0]  lsat;
   logic [LIGHT_W-1:0]  csat;
   logic [PROD1_W-1:0]  lum_prod;
   logic [PROD1_W-1:0]  c_prod;
   logic                s1_valid_ff;
   lsp_pixel_type       s1_pix_ff;
   logic [LUM_W-1:0]    s1_lum_ff;
   logic [LUM_W-1:0]    s1_c_ff;

   // stage 2
   logic [LUM_W:0]      one_minus_c;
   logic [LUM_W:0]      one_minus_b;
   logic [PROD2_W-1:0]  tl_prod;
   logic [PROD2_W-1:0]  th_prod;
   logic [LUM_W:0]      th_sum;
   logic                s2_valid_ff;
   lsp_pixel_type       s2_pix_ff;
   logic [LUM_W-1:0]    s2_lum_ff;
   logic [LUM_W-1:0]    s2_tl_ff;
   logic [LUM_W-1:0]    s2_th_ff;

   // stage 3
   logic                is_shadow;
   logic                is_highlight;
   logic [LUM_W-1:0]    mul_x;
   logic [LUM_W-1:0]    mul_y;
   logic [NUM_W-1:0]    xy_prod;
   lsp_region_type      region;
   logic                s3_valid_ff;
   lsp_pixel_type       s3_pix_ff;
   lsp_region_type      s3_region_ff;
   logic [NUM_W-1:0]    s3_num_ff;
   logic [LUM_W-1:0]    s3_den_ff;

   // stage 4
   lsp_div_type         s4_in;
   logic                s4_valid_ff;
   lsp_div_type         s4_item_ff;

   always_comb begin
      lsat     = (in_pix.lightness > L_MAX) ? L_MAX : in_pix.lightness;
      csat     = (cfg.compress > L_MAX) ? L_MAX : cfg.compress;
      lum_prod = PROD1_W'(lsat) * PROD1_W'(RECIP25);
      c_prod   = PROD1_W'(csat) * PROD1_W'(RECIP25);
   end

   always_comb begin
      one_minus_c = (LUM_W+1)'(FRAC_ONE) - (LUM_W+1)'(s1_c_ff);
      one_minus_b = (LUM_W+1)'(FRAC_ONE) - (LUM_W+1)'(cfg.balance);
      tl_prod     = PROD2_W'(cfg.balance) * PROD2_W'(one_minus_c);
      th_prod     = PROD2_W'(one_minus_b) * PROD2_W'(s1_c_ff);
      th_sum      = (LUM_W+1)'(cfg.balance) + th_prod[16 +: LUM_W+1];
   end

   // Shadow wins over highlight; midtones get a zero numerator.
   always_comb begin
      is_shadow    = s2_lum_ff < s2_tl_ff;
      is_highlight = !is_shadow && (s2_lum_ff > s2_th_ff);
      if (is_shadow) begin
         mul_x  = s2_lum_ff;
         mul_y  = s2_tl_ff - s2_lum_ff;
         region = REGION_SHADOW;
      end else if (is_highlight) begin
         mul_x  = LUM_W'((LUM_W+1)'(FRAC_ONE) - (LUM_W+1)'(s2_lum_ff));
         mul_y  = s2_lum_ff - s2_th_ff;
         region = REGION_HIGHLIGHT;
      end else begin
         mul_x  = '0;
         mul_y  = '0;
         region = REGION_MID;
      end
      xy_prod = NUM_W'(mul_x) * NUM_W'(mul_y);
   end

   // Quotient reaches 2^31 exactly when num >= den * 2^31; a zero divisor
   // with a zero numerator divides by one instead.
   always_comb begin
      s4_in.pix    = s3_pix_ff;
      s4_in.region = s3_region_ff;
      s4_in.rem    = s3_num_ff;
      s4_in.den    = (s3_den_ff == '0) ? LUM_W'(1) : s3_den_ff;
      s4_in.quot   = '0;
      s4_in.sat    = (s3_num_ff != '0) &&
                     (SHIFT_W'(s3_num_ff) >= (SHIFT_W'(s3_den_ff) << RA_W));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_pix_ff    <= in_pix;
         s1_lum_ff    <= lum_prod[RECIP_SHIFT +: LUM_W];
         s1_c_ff      <= c_prod[RECIP_SHIFT +: LUM_W];
         s2_pix_ff    <= s1_pix_ff;
         s2_lum_ff    <= s1_lum_ff;
         s2_tl_ff     <= tl_prod[16 +: LUM_W];
         s2_th_ff     <= th_sum[LUM_W-1:0];
         s3_pix_ff    <= s2_pix_ff;
         s3_region_ff <= region;
         s3_num_ff    <= NUM_W'({xy_prod, 1'b0});
         s3_den_ff    <= is_shadow ? s2_tl_ff : s2_th_ff;
         s4_item_ff   <= s4_in;
      end
   end

   assign out_valid = s4_valid_ff;
   assign out_item  = s4_item_ff;

endmodule

// ===== hw/rtl/lsp_div_stage.sv =====
// ----------------------------------------------------------------------------
// lsp_div_stage
// One restoring division step: resolves quotient bit BIT of the tone weight.
// ----------------------------------------------------------------------------
module lsp_div_stage import lsp_pkg::*; #(
   parameter int unsigned BIT = 0
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        advance,
   input  logic        in_valid,
   input  lsp_div_type in_item,
   output logic        out_valid,
   output lsp_div_type out_item
);

   logic [SHIFT_W-1:0] shifted;
   logic               fits;
   lsp_div_type        next_item;
   logic               valid_ff;
   lsp_div_type        item_ff;

   always_comb begin
      shifted   = SHIFT_W'(in_item.den) << BIT;
      fits      = SHIFT_W'(in_item.rem) >= shifted;
      next_item = in_item;
      if (fits) begin
         next_item.rem       = in_item.rem - shifted[NUM_W-1:0];
         next_item.quot[BIT] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         item_ff <= next_item;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

// ===== hw/rtl/lsp_tint.sv =====
// ----------------------------------------------------------------------------
// lsp_tint
// Tint stages: phase from hue and weight, sine/cosine ROM, chroma scaling,
// rounding and saturating add onto the base a/b; ends in the output register.
// ----------------------------------------------------------------------------
module lsp_tint import lsp_pkg::*; #(
   parameter int unsigned SINE_TABLE_DEPTH = LSP_SINE_DEPTH
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           advance,
   input  lsp_cfg_type    cfg,
   input  logic           in_valid,
   input  lsp_div_type    in_item,
   output logic           out_valid,
   output lsp_result_type out_result
);

   localparam int unsigned IDX_W   = $clog2(SINE_TABLE_DEPTH);
   localparam int unsigned DEPTH_W = $clog2(SINE_TABLE_DEPTH + 1);
   localparam int unsigned IPROD_W = HUE_W + DEPTH_W;
   localparam int unsigned CA_W    = CHROMA_W + CH_W;
   localparam int unsigned MAG_W   = CA_W + RA_W;
   localparam int unsigned SUM_W   = CH_W + 17;

   logic signed [TRIG_W-1:0] sin_rom [SINE_TABLE_DEPTH];
   logic signed [TRIG_W-1:0] cos_rom [SINE_TABLE_DEPTH];

   for (genvar g = 0; g < SINE_TABLE_DEPTH; g++) begin : g_rom
      localparam longint unsigned TURN = (longint'(g) * 65536) / SINE_TABLE_DEPTH;
      assign sin_rom[g] = lsp_turn_sine(32'(TURN));
      assign cos_rom[g] = lsp_turn_sine(32'(TURN + 16384));
   end

   logic [RA_W-1:0]          ra;
   logic [HUE_W-1:0]         hue;
   logic [IPROD_W-1:0]       idx_prod;
   logic [CHROMA_W-1:0]      chroma;
   logic [TRIG_W-1:0]        abs_cos;
   logic [TRIG_W-1:0]        abs_sin;
   logic [MAG_W:0]           rnd_a;
   logic [MAG_W:0]           rnd_b;
   logic signed [SUM_W-1:0]  base_a;
   logic signed [SUM_W-1:0]  base_b;
   logic signed [SUM_W-1:0]  sum_a;
   logic signed [SUM_W-1:0]  sum_b;
   logic signed [SUM_W-1:0]  d_a;
   logic signed [SUM_W-1:0]  d_b;
   lsp_result_type           result;

   logic                     t1_valid_ff, t2_valid_ff, t3_valid_ff;
   logic                     t4_valid_ff, t5_valid_ff, t6_valid_ff;
   lsp_pixel_type            t1_pix_ff, t2_pix_ff, t3_pix_ff;
   lsp_pixel_type            t4_pix_ff, t5_pix_ff, t6_pix_ff;
   lsp_region_type           t1_region_ff, t2_region_ff, t3_region_ff;
   lsp_region_type           t4_region_ff, t5_region_ff, t6_region_ff;
   logic [RA_W-1:0]          t1_ra_ff, t2_ra_ff, t3_ra_ff, t4_ra_ff, t5_ra_ff;
   logic [2*HUE_W-1:0]       t1_lo_ff;
   logic [2*HUE_W-2:0]       t1_hi_ff;
   logic [HUE_W-1:0]         t2_p_ff;
   logic [IDX_W-1:0]         t3_idx_ff;
   logic signed [TRIG_W-1:0] t4_sin_ff;
   logic signed [TRIG_W-1:0] t4_cos_ff;
   logic [CA_W-1:0]          t5_ca_ff;
   logic [CA_W-1:0]          t5_cb_ff;
   logic                     t5_neg_a_ff, t5_neg_b_ff;
   logic [MAG_W-1:0]         t6_mag_a_ff;
   logic [MAG_W-1:0]         t6_mag_b_ff;
   logic                     t6_neg_a_ff, t6_neg_b_ff;
   logic                     out_valid_ff;
   lsp_result_type           out_ff;

   // Saturated weight and hue pick; midtones carry a zero weight.
   always_comb begin
      ra  = in_item.sat ? RA_MAX : in_item.quot;
      hue = (in_item.region == REGION_HIGHLIGHT) ? cfg.bright_hue : cfg.dark_hue;
   end

   always_comb begin
      idx_prod = IPROD_W'(t2_p_ff) * IPROD_W'(SINE_TABLE_DEPTH);
   end

   always_comb begin
      chroma  = (t4_region_ff == REGION_HIGHLIGHT) ? cfg.bright_chroma
                                                   : cfg.dark_chroma;
      abs_cos = t4_cos_ff[TRIG_W-1] ? TRIG_W'(-t4_cos_ff) : TRIG_W'(t4_cos_ff);
      abs_sin = t4_sin_ff[TRIG_W-1] ? TRIG_W'(-t4_sin_ff) : TRIG_W'(t4_sin_ff);
   end

   // Round half away from zero on the magnitude, then restore the sign.
   always_comb begin
      rnd_a  = (MAG_W+1)'(t6_mag_a_ff) + ((MAG_W+1)'(1) << 30);
      rnd_b  = (MAG_W+1)'(t6_mag_b_ff) + ((MAG_W+1)'(1) << 30);
      d_a    = $signed(SUM_W'(rnd_a[MAG_W:31]));
      d_b    = $signed(SUM_W'(rnd_b[MAG_W:31]));
      if (t6_neg_a_ff) begin
         d_a = -d_a;
      end
      if (t6_neg_b_ff) begin
         d_b = -d_b;
      end
      base_a = cfg.has_chroma ? $signed({{(SUM_W-CH_W){t6_pix_ff.chan_a[CH_W-1]}},
                                         t6_pix_ff.chan_a}) : '0;
      base_b = cfg.has_chroma ? $signed({{(SUM_W-CH_W){t6_pix_ff.chan_b[CH_W-1]}},
                                         t6_pix_ff.chan_b}) : '0;
      sum_a  = base_a + d_a;
      sum_b  = base_b + d_b;

      result.out_lightness = t6_pix_ff.lightness;
      result.out_extra     = t6_pix_ff.extra_word;
      result.out_frame_end = t6_pix_ff.frame_end;
      result.tone_region   = t6_region_ff;
      if (sum_a > SUM_W'(32767)) begin
         result.out_a = 16'h7FFF;
      end else if (sum_a < -SUM_W'(32768)) begin
         result.out_a = 16'h8000;
      end else begin
         result.out_a = sum_a[CH_W-1:0];
      end
      if (sum_b > SUM_W'(32767)) begin
         result.out_b = 16'h7FFF;
      end else if (sum_b < -SUM_W'(32768)) begin
         result.out_b = 16'h8000;
      end else begin
         result.out_b = sum_b[CH_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         t1_valid_ff  <= 1'b0;
         t2_valid_ff  <= 1'b0;
         t3_valid_ff  <= 1'b0;
         t4_valid_ff  <= 1'b0;
         t5_valid_ff  <= 1'b0;
         t6_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         t1_valid_ff  <= in_valid;
         t2_valid_ff  <= t1_valid_ff;
         t3_valid_ff  <= t2_valid_ff;
         t4_valid_ff  <= t3_valid_ff;
         t5_valid_ff  <= t4_valid_ff;
         t6_valid_ff  <= t5_valid_ff;
         out_valid_ff <= t6_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         // phase products: only bits [31:16] of hue*ra survive the wrap
         t1_pix_ff    <= in_item.pix;
         t1_region_ff <= in_item.region;
         t1_ra_ff     <= ra;
         t1_lo_ff     <= (2*HUE_W)'(hue) * (2*HUE_W)'(ra[HUE_W-1:0]);
         t1_hi_ff     <= (2*HUE_W-1)'(hue) * (2*HUE_W-1)'(ra[RA_W-1:HUE_W]);

         t2_pix_ff    <= t1_pix_ff;
         t2_region_ff <= t1_region_ff;
         t2_ra_ff     <= t1_ra_ff;
         t2_p_ff      <= t1_lo_ff[2*HUE_W-1:HUE_W] + t1_hi_ff[HUE_W-1:0];

         t3_pix_ff    <= t2_pix_ff;
         t3_region_ff <= t2_region_ff;
         t3_ra_ff     <= t2_ra_ff;
         t3_idx_ff    <= idx_prod[HUE_W +: IDX_W];

         t4_pix_ff    <= t3_pix_ff;
         t4_region_ff <= t3_region_ff;
         t4_ra_ff     <= t3_ra_ff;
         t4_sin_ff    <= sin_rom[t3_idx_ff];
         t4_cos_ff    <= cos_rom[t3_idx_ff];

         t5_pix_ff    <= t4_pix_ff;
         t5_region_ff <= t4_region_ff;
         t5_ra_ff     <= t4_ra_ff;
         t5_ca_ff     <= CA_W'(chroma) * CA_W'(abs_cos[CH_W-1:0]);
         t5_cb_ff     <= CA_W'(chroma) * CA_W'(abs_sin[CH_W-1:0]);
         t5_neg_a_ff  <= t4_cos_ff[TRIG_W-1];
         t5_neg_b_ff  <= t4_sin_ff[TRIG_W-1];

         t6_pix_ff    <= t5_pix_ff;
         t6_region_ff <= t5_region_ff;
         t6_mag_a_ff  <= MAG_W'(t5_ca_ff) * MAG_W'(t5_ra_ff);
         t6_mag_b_ff  <= MAG_W'(t5_cb_ff) * MAG_W'(t5_ra_ff);
         t6_neg_a_ff  <= t5_neg_a_ff;
         t6_neg_b_ff  <= t5_neg_b_ff;

         out_ff       <= result;
      end
   end

   assign out_valid  = out_valid_ff;
   assign out_result = out_ff;

`ifndef SYNTHESIS
   a_sat_only_highlight: assert property (@(posedge clock) disable iff (reset)
      (in_valid && in_item.sat) |-> (in_item.region == REGION_HIGHLIGHT))
      else $error("saturated tone weight outside the highlights");

   a_shadow_weight_narrow: assert property (@(posedge clock) disable iff (reset)
      (in_valid && in_item.region == REGION_SHADOW) |-> (ra[RA_W-1:LUM_W] == '0))
      else $error("shadow tone weight exceeds twice the lightness range");

   a_midtone_passes: assert property (@(posedge clock) disable iff (reset)
      (advance && t6_valid_ff && t6_region_ff == REGION_MID) |=>
      (out_ff.out_a == $past(base_a[CH_W-1:0]) && out_ff.out_b == $past(base_b[CH_W-1:0])))
      else $error("midtone pixel altered");
`endif

endmodule

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Split-tone pixel pipeline test: directed and random Lab pixels under
// several register settings, with random idling on both channels in most
// phases. A scoreboard predicts each toned pixel and checks the response stream.
// ----------------------------------------------------------------------------
import lsp_pkg::*;

class tone_scoreboard;
   lsp_result_type pending_q[$];
   lsp_cfg_type    cfg;
   int             errors;

   function new();
      errors = 0;
   endfunction

   // Sine of a Q0.16 turn in Q1.15: quadrant fold plus a Taylor series in Q28.
   function longint turn_sin(logic [15:0] turn);
      longint unsigned f, r, r2, t, s;
      f = turn[13:0];
      if (turn[14]) begin
         f = 16384 - f;
      end
      r  = (f * 64'd1686629713) >> 16;
      r2 = (r * r) >> 28;
      t  = 64'd268435456 - r2 / 110;
      t  = 64'd268435456 - ((r2 * t) >> 28) / 72;
      t  = 64'd268435456 - ((r2 * t) >> 28) / 42;
      t  = 64'd268435456 - ((r2 * t) >> 28) / 20;
      t  = 64'd268435456 - ((r2 * t) >> 28) / 6;
      s  = (r * t) >> 28;
      s  = (s + 4096) >> 13;
      if (s > 32768) begin
         s = 32768;
      end
      return turn[15] ? -longint'(s) : longint'(s);
   endfunction

   function longint tint_offset(longint unsigned chroma, longint unsigned ra, longint trig);
      longint unsigned mag;
      longint          d;
      mag = chroma * ra * longint'(trig < 0 ? -trig : trig);
      d = longint'((mag + (64'd1 << 30)) >> 31);
      return trig < 0 ? -d : d;
   endfunction

   function logic [15:0] clamp16(longint v);
      if (v > 32767) begin
         v = 32767;
      end
      if (v < -32768) begin
         v = -32768;
      end
      return v[15:0];
   endfunction

   // note one accepted pixel and queue its toned result
   function void note_pixel(lsp_pixel_type px);
      longint unsigned lum, c, tl, th, ra, hue, chroma, num, p, idx;
      longint          base_a, base_b;
      logic [15:0]     t;
      lsp_result_type  res;
      lum = ((px.lightness > 25600 ? 25600 : px.lightness) * 64) / 25;
      c   = ((cfg.compress > 25600 ? 25600 : cfg.compress) * 64) / 25;
      tl  = (cfg.balance * (65536 - c)) >> 16;
      th  = cfg.balance + (((65536 - cfg.balance) * c) >> 16);
      base_a = cfg.has_chroma ? longint'($signed(px.chan_a)) : 0;
      base_b = cfg.has_chroma ? longint'($signed(px.chan_b)) : 0;
      res.tone_region = REGION_MID;
      ra = 0;
      hue = 0;
      chroma = 0;
      if (lum < tl) begin
         res.tone_region = REGION_SHADOW;
         ra = (2 * lum * (tl - lum)) / tl;
         hue = cfg.dark_hue;
         chroma = cfg.dark_chroma;
      end else if (lum > th) begin
         num = 2 * (65536 - lum) * (lum - th);
         res.tone_region = REGION_HIGHLIGHT;
         if (th == 0) begin
            ra = num != 0 ? 64'h7FFFFFFF : 0;
         end else begin
            ra = num / th;
         end
         if (ra > 64'h7FFFFFFF) begin
            ra = 64'h7FFFFFFF;
         end
         hue = cfg.bright_hue;
         chroma = cfg.bright_chroma;
      end
      if (res.tone_region != REGION_MID) begin
         p   = ((hue * ra) >> 16) & 64'hFFFF;
         idx = (p * LSP_SINE_DEPTH) >> 16;
         t   = 16'((idx * 65536) / LSP_SINE_DEPTH);
         base_a += tint_offset(chroma, ra, turn_sin(t + 16'd16384));
         base_b += tint_offset(chroma, ra, turn_sin(t));
      end
      res.out_lightness = px.lightness;
      res.out_a = clamp16(base_a);
      res.out_b = clamp16(base_b);
      res.out_extra = px.extra_word;
      res.out_frame_end = px.frame_end;
      pending_q.push_back(res);
   endfunction

   function void check_result(lsp_result_type got);
      lsp_result_type exp;
      if (pending_q.size() == 0) begin
         $display("%0t: unexpected response %p", $time, got);
         errors++;
         return;
      end
      exp = pending_q.pop_front();
      if (got !== exp) begin
         $display("%0t: mismatch expected %p actual %p", $time, exp, got);
         errors++;
      end
   endfunction
endclass

module tb_top;
   localparam int LATENCY = 42;
   localparam int WATCHDOG_LIMIT = 4000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   lsp_csr_type csr_index = CSR_DARK_HUE;
   logic [CSR_W-1:0] csr_wdata = '0;

   lsp_req_if req_if();
   lsp_rsp_if rsp_if();

   tone_scoreboard tone_sb;
   int  send_idle_pct;
   int  recv_idle_pct;
   int  idle_cycles;
   bit  timed_out;
   lsp_result_type rsp_beat;

   lab_split_tone_pixel uut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if.sink),
      .rsp_if    (rsp_if.source),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   initial begin
      req_if.valid = 1'b0;
      req_if.lightness = '0;
      req_if.chan_a = '0;
      req_if.chan_b = '0;
      req_if.extra_word = '0;
      req_if.frame_end = 1'b0;
      rsp_if.ready = 1'b0;
   end

   assign rsp_beat = '{out_lightness: rsp_if.out_lightness, out_a: rsp_if.out_a,
                       out_b: rsp_if.out_b, out_extra: rsp_if.out_extra,
                       tone_region: lsp_region_type'(rsp_if.tone_region),
                       out_frame_end: rsp_if.out_frame_end};

   // sample responses at the rising edge; count idle cycles with no beat on either channel
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready) begin
            tone_sb.check_result(rsp_beat);
         end
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            idle_cycles <= 0;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   // receiver: stall at random, decided on the falling edge
   always @(negedge clock) begin
      rsp_if.ready <= !reset && ($urandom_range(99) >= recv_idle_pct);
   end

   // watchdog: end the run if nothing moves for too long
   always @(posedge clock) begin
      if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
         timed_out = 1'b1;
         $display("tb: failure");
         $finish;
      end
   end

   // write one register at the falling edge, hold it across a rising edge
   task automatic write_reg(lsp_csr_type idx, int unsigned value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_W'(value);
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_DARK_HUE:      tone_sb.cfg.dark_hue = value[15:0];
         CSR_DARK_CHROMA:   tone_sb.cfg.dark_chroma = value[14:0];
         CSR_BRIGHT_HUE:    tone_sb.cfg.bright_hue = value[15:0];
         CSR_BRIGHT_CHROMA: tone_sb.cfg.bright_chroma = value[14:0];
         CSR_BALANCE:       tone_sb.cfg.balance = value[15:0];
         CSR_COMPRESS:      tone_sb.cfg.compress = value[14:0];
         CSR_HAS_CHROMA:    tone_sb.cfg.has_chroma = value[0];
         default: ;
      endcase
   endtask

   task automatic write_all(int unsigned sh, int unsigned sc, int unsigned hh,
                            int unsigned hc, int unsigned bal, int unsigned cmp,
                            int unsigned hasc);
      write_reg(CSR_DARK_HUE, sh);
      write_reg(CSR_DARK_CHROMA, sc);
      write_reg(CSR_BRIGHT_HUE, hh);
      write_reg(CSR_BRIGHT_CHROMA, hc);
      write_reg(CSR_BALANCE, bal);
      write_reg(CSR_COMPRESS, cmp);
      write_reg(CSR_HAS_CHROMA, hasc);
   endtask

   // drive one pixel beat; hold valid until the sink takes it
   task automatic send_pixel(lsp_pixel_type px);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.lightness <= px.lightness;
      req_if.chan_a <= px.chan_a;
      req_if.chan_b <= px.chan_b;
      req_if.extra_word <= px.extra_word;
      req_if.frame_end <= px.frame_end;
      do begin
         @(posedge clock);
      end while (!req_if.ready);
      tone_sb.note_pixel(px);
      @(negedge clock);
   endtask

   task automatic send_fields(int unsigned l, int unsigned a, int unsigned b,
                              int unsigned x, bit fe);
      lsp_pixel_type px;
      px.lightness = l[14:0];
      px.chan_a = a[15:0];
      px.chan_b = b[15:0];
      px.extra_word = x;
      px.frame_end = fe;
      send_pixel(px);
   endtask

   // mostly legal lightness, with raw values past 100 now and then
   task automatic send_random(int unsigned count);
      int unsigned l;
      repeat (count) begin
         l = ($urandom_range(9) == 0) ? $urandom_range(32767) : $urandom_range(25600);
         send_fields(l, $urandom, $urandom, $urandom, $urandom_range(15) == 0);
      end
   endtask

   // let the pipeline drain before touching the registers
   task automatic drain();
      req_if.valid <= 1'b0;
      while (tone_sb.pending_q.size() != 0) begin
         @(negedge clock);
      end
      repeat (LATENCY + 4) @(negedge clock);
   endtask

   task automatic random_config();
      int unsigned bal;
      int unsigned cmp;
      case ($urandom_range(3))
         0: bal = $urandom_range(65535);
         1: bal = $urandom_range(1) ? 0 : 65535;
         default: bal = $urandom_range(16384, 49152);
      endcase
      cmp = ($urandom_range(7) == 0) ? $urandom_range(25601, 32767) : $urandom_range(25600);
      write_all($urandom_range(65535), $urandom_range(16384), $urandom_range(65535),
                $urandom_range(16384), bal, cmp, $urandom_range(1));
   endtask

   initial begin
      tone_sb = new();
      tone_sb.cfg = '{dark_hue: 0, dark_chroma: 7680, bright_hue: 13107,
                      bright_chroma: 7680, balance: 32768, compress: 8448,
                      has_chroma: 1'b1};
      idle_cycles = 0;
      timed_out = 1'b0;
      send_idle_pct = 24;
      recv_idle_pct = 49;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: reset defaults, field extremes, deep shadow and highlight
      send_fields(0, 16'h8000, 16'h7FFF, 0, 1'b0);
      send_fields(25600, 16'h7FFF, 16'h8000, 32'hFFFFFFFF, 1'b1);
      send_fields(32767, 16'hFFFF, 16'h0000, 32'hA5A5A5A5, 1'b0);
      send_fields(12800, 16'h1234, 16'hEDCB, 32'h5A5A5A5A, 1'b1);
      send_fields(3000, 16'h7FF0, 16'h8010, 1, 1'b0);
      send_fields(24000, 16'h8010, 16'h7FF0, 2, 1'b0);
      send_fields(6400, 0, 0, 3, 1'b0);
      send_fields(19200, 0, 0, 4, 1'b1);
      drain();

      // extremes: zero balance gives zero high threshold
      write_all(65535, 16384, 65535, 16384, 0, 0, 1);
      send_fields(0, 0, 0, 0, 1'b0);
      send_fields(1, 16'h7FFF, 16'h7FFF, 0, 1'b0);
      send_fields(25600, 16'h8000, 16'h8000, 0, 1'b0);
      send_fields(12800, 16'h7F00, 16'h8100, 0, 1'b0);
      drain();
      // full balance, compress beyond 100 percent, no chroma
      write_all(0, 0, 0, 0, 65535, 32767, 0);
      send_fields(100, 16'h7FFF, 16'h8000, 0, 1'b0);
      send_fields(25600, 16'h7FFF, 16'h8000, 0, 1'b1);
      drain();
      write_all(12345, 16384, 54321, 16384, 65535, 0, 1);
      send_fields(0, 16'h7FFF, 16'h8000, 0, 1'b0);
      send_fields(25599, 16'h7FFF, 16'h8000, 0, 1'b0);
      send_fields(12800, 16'h8000, 16'h7FFF, 0, 1'b0);
      drain();

      // random phases, idling swapped, then none
      for (int phase = 0; phase < 9; phase++) begin
         if (phase == 3) begin
            send_idle_pct = 49;
            recv_idle_pct = 24;
         end else if (phase == 6) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         random_config();
         send_random(210);
         drain();
      end

      if (tone_sb.errors == 0 && tone_sb.pending_q.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end
endmodule
